[rtl/core/tldm_pkg.sv]
// Shared types, constants and helpers for the task list deque manager.
// No dependencies; tldm_if and the top level refer to it by scoped names.
package tldm_pkg;

  localparam int NUM_TASKS = 16;
  localparam int NUM_LISTS = 4;

  // Field widths of the request and response.
  localparam int CMD_W    = 3;
  localparam int LIST_W   = 2;
  localparam int TASK_W   = 4;
  localparam int LINK_W   = 5;
  localparam int ADDR_W   = $clog2(NUM_TASKS);

  localparam logic [LINK_W-1:0] TASK_NONE = LINK_W'(NUM_TASKS);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_BACK   = 3'd0,
    CMD_ADD_FRONT  = 3'd1,
    CMD_DROP_BACK  = 3'd2,
    CMD_DROP_FRONT = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LIST_W-1:0] list_index;
    logic [TASK_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [LINK_W-1:0] new_head;
    logic [LINK_W-1:0] new_tail;
    logic [TASK_W-1:0] removed_task;
    logic              removed_valid;
  } rsp_t;

  function automatic logic is_task(input logic [LINK_W-1:0] t);
    return t < TASK_NONE;
  endfunction

endpackage

[rtl/core/tldm_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on tldm_pkg for the payload structs.
interface tldm_req_if;
  logic            valid;
  logic            ready;
  tldm_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tldm_rsp_if;
  logic            valid;
  logic            ready;
  tldm_pkg::rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/task_list_deque_manager_top.sv]
// Top level of the task list deque manager: head/tail registers, link RAMs, sequencer.
// Depends on tldm_pkg, tldm_if (tldm_req_if, tldm_rsp_if) and tldm_ram.
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+-----------
//  req     | in  | cmd, list_index, task_id                         | valid/ready
//  rsp     | out | new_head, new_tail, removed_task, removed_valid  | valid/ready
//
// A request is accepted in ST_IDLE: the accept cycle issues the link RAM reads (and,
// for an add, the first link writes); ST_FIN then does the dependent link write, the
// head/tail update and loads the response register. The split comes from the single
// write port of each link RAM. Reset clears the head/tail registers to empty at once;
// no clearing pass; ready stays low while rst is high. A request is taken only when
// the response register is empty or being drained, so a stalled response holds off
// the next request.
module task_list_deque_manager_top (
  input  logic             clk,
  input  logic             rst,
  tldm_req_if.sink         req,
  tldm_rsp_if.source       rsp
);

  localparam int LW = tldm_pkg::LINK_W;
  localparam int AW = tldm_pkg::ADDR_W;

  tldm_pkg::state_t state, state_next;

  // Per-list head and tail, in flops: reset must set them to empty.
  logic [LW-1:0] list_head [tldm_pkg::NUM_LISTS];
  logic [LW-1:0] list_tail [tldm_pkg::NUM_LISTS];

  // Request held for ST_FIN.
  logic [tldm_pkg::CMD_W-1:0]  op_cmd;
  logic [tldm_pkg::LIST_W-1:0] op_list;
  logic [tldm_pkg::TASK_W-1:0] op_task;
  logic [LW-1:0]               op_head;
  logic [LW-1:0]               op_tail;
  logic                        op_list_ok;
  logic                        op_task_ok;

  // Response register.
  logic           rsp_valid;
  tldm_pkg::rsp_t rsp_data;

  // Link RAM ports.
  logic          nx_we, pv_we, link_re;
  logic [AW-1:0] nx_waddr, pv_waddr, nx_raddr, pv_raddr;
  logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  // Decoded request at the port.
  logic          accept;
  logic          in_list_ok, in_task_ok;
  logic [LW-1:0] in_task, cur_head, cur_tail;

  // ST_FIN results.
  logic [LW-1:0]               head_new, tail_new;
  logic [tldm_pkg::TASK_W-1:0] rem_task;
  logic                        rem_valid;

  assign req.ready = !rst && (state == tldm_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign in_list_ok = {1'b0, req.payload.list_index} < 3'(tldm_pkg::NUM_LISTS);
  assign in_task    = {1'b0, req.payload.task_id};
  assign in_task_ok = tldm_pkg::is_task(in_task);
  assign cur_head   = in_list_ok ? list_head[req.payload.list_index] : tldm_pkg::TASK_NONE;
  assign cur_tail   = in_list_ok ? list_tail[req.payload.list_index] : tldm_pkg::TASK_NONE;

  // next_link and prev_link. Owner tags are never read back, so they are not kept.
  tldm_ram #(.WIDTH(LW), .DEPTH(tldm_pkg::NUM_TASKS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (link_re),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  tldm_ram #(.WIDTH(LW), .DEPTH(tldm_pkg::NUM_TASKS)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (link_re),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  // Read addresses: drops follow the end task, delete reads both links of the task.
  always_comb begin
    link_re  = accept;
    nx_raddr = req.payload.task_id;
    pv_raddr = req.payload.task_id;
    if (req.payload.cmd == tldm_pkg::CMD_DROP_FRONT) begin
      nx_raddr = cur_head[AW-1:0];
    end
    if (req.payload.cmd == tldm_pkg::CMD_DROP_BACK) begin
      pv_raddr = cur_tail[AW-1:0];
    end
  end

  // Sequencer, link writes and ST_FIN head/tail update.
  always_comb begin
    state_next = state;
    nx_we      = 1'b0;
    nx_waddr   = req.payload.task_id;
    nx_wdata   = tldm_pkg::TASK_NONE;
    pv_we      = 1'b0;
    pv_waddr   = req.payload.task_id;
    pv_wdata   = tldm_pkg::TASK_NONE;
    head_new   = op_head;
    tail_new   = op_tail;
    rem_task   = '0;
    rem_valid  = 1'b0;

    case (state)
      tldm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = tldm_pkg::ST_FIN;
          // Adds write the new task's own links right away.
          if (in_list_ok && in_task_ok) begin
            case (req.payload.cmd)
              tldm_pkg::CMD_ADD_BACK: begin
                nx_we    = 1'b1;
                nx_wdata = tldm_pkg::TASK_NONE;
                pv_we    = 1'b1;
                pv_wdata = cur_tail;
              end
              tldm_pkg::CMD_ADD_FRONT: begin
                nx_we    = 1'b1;
                nx_wdata = cur_head;
                pv_we    = 1'b1;
                pv_wdata = tldm_pkg::TASK_NONE;
              end
              default: begin
              end
            endcase
          end
        end
      end

      tldm_pkg::ST_FIN: begin
        state_next = tldm_pkg::ST_IDLE;
        if (!op_list_ok) begin
          head_new = tldm_pkg::TASK_NONE;
          tail_new = tldm_pkg::TASK_NONE;
        end else begin
          case (op_cmd)
            tldm_pkg::CMD_ADD_BACK: begin
              if (op_task_ok) begin
                if (tldm_pkg::is_task(op_tail)) begin
                  nx_we    = 1'b1;
                  nx_waddr = op_tail[AW-1:0];
                  nx_wdata = {1'b0, op_task};
                end
                tail_new = {1'b0, op_task};
                if (!tldm_pkg::is_task(op_head)) begin
                  head_new = {1'b0, op_task};
                end
              end
            end
            tldm_pkg::CMD_ADD_FRONT: begin
              if (op_task_ok) begin
                if (tldm_pkg::is_task(op_head)) begin
                  pv_we    = 1'b1;
                  pv_waddr = op_head[AW-1:0];
                  pv_wdata = {1'b0, op_task};
                end
                head_new = {1'b0, op_task};
                if (!tldm_pkg::is_task(op_tail)) begin
                  tail_new = {1'b0, op_task};
                end
              end
            end
            tldm_pkg::CMD_DROP_BACK: begin
              if (tldm_pkg::is_task(op_tail)) begin
                rem_task  = op_tail[tldm_pkg::TASK_W-1:0];
                rem_valid = 1'b1;
                tail_new  = pv_rdata;
                if (tldm_pkg::is_task(pv_rdata)) begin
                  nx_we    = 1'b1;
                  nx_waddr = pv_rdata[AW-1:0];
                  nx_wdata = tldm_pkg::TASK_NONE;
                end
                if (op_tail == op_head) begin
                  head_new = tldm_pkg::TASK_NONE;
                end
              end
            end
            tldm_pkg::CMD_DROP_FRONT: begin
              if (tldm_pkg::is_task(op_head)) begin
                rem_task  = op_head[tldm_pkg::TASK_W-1:0];
                rem_valid = 1'b1;
                head_new  = nx_rdata;
                if (tldm_pkg::is_task(nx_rdata)) begin
                  pv_we    = 1'b1;
                  pv_waddr = nx_rdata[AW-1:0];
                  pv_wdata = tldm_pkg::TASK_NONE;
                end
                if (op_head == op_tail) begin
                  tail_new = tldm_pkg::TASK_NONE;
                end
              end
            end
            tldm_pkg::CMD_DELETE: begin
              if (op_task_ok) begin
                rem_task  = op_task;
                rem_valid = 1'b1;
                if (op_head == {1'b0, op_task}) begin
                  // head: same as a front drop
                  head_new = nx_rdata;
                  if (tldm_pkg::is_task(nx_rdata)) begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata[AW-1:0];
                    pv_wdata = tldm_pkg::TASK_NONE;
                  end
                  if (op_head == op_tail) begin
                    tail_new = tldm_pkg::TASK_NONE;
                  end
                end else if (op_tail == {1'b0, op_task}) begin
                  // tail: same as a back drop
                  tail_new = pv_rdata;
                  if (tldm_pkg::is_task(pv_rdata)) begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata[AW-1:0];
                    nx_wdata = tldm_pkg::TASK_NONE;
                  end
                end else begin
                  // middle: splice neighbors through the task's own links
                  if (tldm_pkg::is_task(nx_rdata)) begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata[AW-1:0];
                    pv_wdata = pv_rdata;
                  end
                  if (tldm_pkg::is_task(pv_rdata)) begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata[AW-1:0];
                    nx_wdata = nx_rdata;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_next = tldm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tldm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Head/tail registers: reset to empty, rewritten at the end of each request with a valid list index.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tldm_pkg::NUM_LISTS; i++) begin
        list_head[i] <= tldm_pkg::TASK_NONE;
        list_tail[i] <= tldm_pkg::TASK_NONE;
      end
    end else if (state == tldm_pkg::ST_FIN && op_list_ok) begin
      list_head[op_list] <= head_new;
      list_tail[op_list] <= tail_new;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd     <= req.payload.cmd;
      op_list    <= req.payload.list_index;
      op_task    <= req.payload.task_id;
      op_head    <= cur_head;
      op_tail    <= cur_tail;
      op_list_ok <= in_list_ok;
      op_task_ok <= in_task_ok;
    end
  end

  // Response register; empty or draining whenever ST_FIN runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == tldm_pkg::ST_FIN) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tldm_pkg::ST_FIN) begin
      rsp_data.new_head      <= head_new;
      rsp_data.new_tail      <= tail_new;
      rsp_data.removed_task  <= rem_task;
      rsp_data.removed_valid <= rem_valid;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

endmodule

[rtl/core/tldm_ram.sv]
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module tldm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
